>>> hdl/der2raw_pkg.sv
package der2raw_pkg;

	localparam int COORD_BYTES = 32;
	localparam int DER_MAX_BYTES = 72;
	localparam int DER_MIN_BYTES = 8;
	localparam int STORE_BYTES = 2 * COORD_BYTES;
	localparam int WORD_COUNT = (STORE_BYTES + 7) / 8;
	localparam int STORE_AW = $clog2(STORE_BYTES);
	localparam int WORD_AW = $clog2(WORD_COUNT);

	localparam logic [7:0] TAG_SEQUENCE = 8'h30;
	localparam logic [7:0] TAG_INTEGER = 8'h02;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  word_index;
		logic [63:0] out_word;
		logic        ok;
		logic        last_word;
	} word_item_t;

endpackage

>>> hdl/der_ecdsa_signature_to_raw_core.sv
// Channel  | Direction | Handshake               | Payload
// byte     | in        | byte_valid / byte_stall | der2raw_pkg::byte_item_t
// word     | out       | word_valid / word_stall | der2raw_pkg::word_item_t
//
// A DER byte is parsed in the cycle it is accepted, one byte per cycle while byte_stall is low.
// The final byte loads eight result words into an output buffer, which then
// drains one word per cycle when word_stall is low, while the next signature is already being parsed.
// A final byte is stalled only while the buffer still holds undelivered words.
// arst_n returns the parser and the output buffer to idle at once.
module der_ecdsa_signature_to_raw_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  der2raw_pkg::byte_item_t byte_item,
	output logic                    word_valid,
	input  logic                    word_stall,
	output der2raw_pkg::word_item_t word_item
);

	localparam logic [2:0] PH_SEQ_TAG = 3'd0;
	localparam logic [2:0] PH_SEQ_LEN = 3'd1;
	localparam logic [2:0] PH_INT_TAG = 3'd2;
	localparam logic [2:0] PH_INT_LEN = 3'd3;
	localparam logic [2:0] PH_INT_FIRST = 3'd4;
	localparam logic [2:0] PH_INT_STRIPPED = 3'd5;
	localparam logic [2:0] PH_INT_BODY = 3'd6;
	localparam logic [2:0] PH_DONE = 3'd7;

	localparam int SA = der2raw_pkg::STORE_AW;
	localparam int WA = der2raw_pkg::WORD_AW;
	localparam int NW = der2raw_pkg::WORD_COUNT;

	// Parser state.
	logic [2:0] phase_q, phase_n;
	logic [6:0] count_q, count_n;
	logic [7:0] decl_q, decl_n;
	logic       second_q, second_n;
	logic [5:0] left_q, left_n;
	logic       fail_q, fail_n, fail_eff;
	logic       put, clr_half;

	// Coordinate store: byte lanes of 64-bit words, with a valid bit per byte.
	logic [63:0]            store_q [NW];
	logic [NW*8-1:0]        valid_q;
	logic [SA-1:0]          wr_pos;
	logic [WA-1:0]          wr_word;
	logic [2:0]             wr_lane;
	logic [63:0]            snap [NW];
	logic                   ok_n;

	// Output buffer.
	logic [63:0]   buf_q [NW];
	logic          buf_ok_q;
	logic          busy_q;
	logic [WA-1:0] idx_q;

	logic [7:0] b;
	logic       accept, load, out_fire, drain_done;

	assign b = byte_item.data_byte;
	assign out_fire = busy_q && !word_stall;
	assign drain_done = out_fire && (idx_q == WA'(NW - 1));
	assign byte_stall = byte_item.last_byte && busy_q && !drain_done;
	assign accept = byte_valid && !byte_stall;
	assign load = accept && byte_item.last_byte;

	assign wr_pos = SA'(der2raw_pkg::COORD_BYTES) - SA'(left_q)
		+ (second_q ? SA'(der2raw_pkg::COORD_BYTES) : SA'(0));
	assign wr_word = wr_pos[SA-1:3];
	assign wr_lane = wr_pos[2:0];

	always_comb begin
		count_n = (count_q <= 7'(der2raw_pkg::DER_MAX_BYTES)) ? count_q + 7'd1 : count_q;
		fail_eff = fail_q || (count_n > 7'(der2raw_pkg::DER_MAX_BYTES));
		phase_n = phase_q;
		decl_n = decl_q;
		second_n = second_q;
		left_n = left_q;
		fail_n = fail_eff;
		put = 1'b0;
		clr_half = 1'b0;
		if (!fail_eff) begin
			case (phase_q)
				PH_SEQ_TAG: begin
					if (b != der2raw_pkg::TAG_SEQUENCE) fail_n = 1'b1;
					else phase_n = PH_SEQ_LEN;
				end
				PH_SEQ_LEN: begin
					decl_n = b;
					phase_n = PH_INT_TAG;
				end
				PH_INT_TAG: begin
					if (b != der2raw_pkg::TAG_INTEGER) fail_n = 1'b1;
					else phase_n = PH_INT_LEN;
				end
				PH_INT_LEN: begin
					if (b == 8'd0 || b > 8'(der2raw_pkg::COORD_BYTES + 1)) begin
						fail_n = 1'b1;
					end else begin
						left_n = b[5:0];
						clr_half = 1'b1;
						phase_n = PH_INT_FIRST;
					end
				end
				PH_INT_FIRST: begin
					if (b[7]) begin
						fail_n = 1'b1;
					end else if (b == 8'd0 && left_q > 6'd1) begin
						// A single leading zero is allowed only in front of a set top bit.
						left_n = left_q - 6'd1;
						phase_n = PH_INT_STRIPPED;
					end else if (left_q > 6'(der2raw_pkg::COORD_BYTES)) begin
						fail_n = 1'b1;
					end else begin
						put = 1'b1;
					end
				end
				PH_INT_STRIPPED: begin
					if (!b[7] || left_q > 6'(der2raw_pkg::COORD_BYTES)) fail_n = 1'b1;
					else put = 1'b1;
				end
				PH_INT_BODY: begin
					put = 1'b1;
				end
				default: begin
					fail_n = 1'b1;
				end
			endcase
		end
		if (put) begin
			left_n = left_q - 6'd1;
			if (left_q == 6'd1) begin
				if (!second_q) begin
					second_n = 1'b1;
					phase_n = PH_INT_TAG;
				end else begin
					phase_n = PH_DONE;
				end
			end else begin
				phase_n = PH_INT_BODY;
			end
		end
	end

	assign ok_n = !fail_n && phase_n == PH_DONE
		&& count_n >= 7'(der2raw_pkg::DER_MIN_BYTES)
		&& count_n <= 7'(der2raw_pkg::DER_MAX_BYTES)
		&& ({1'b0, decl_n} + 9'd2) == {2'b00, count_n};

	// Store contents as they stand after this byte, zeroed unless the signature is good.
	always_comb begin
		for (int w = 0; w < NW; w++) begin
			for (int k = 0; k < 8; k++) begin
				if (!ok_n) begin
					snap[w][63-8*k -: 8] = 8'd0;
				end else if (put && wr_word == WA'(w) && wr_lane == 3'(k)) begin
					snap[w][63-8*k -: 8] = b;
				end else if (valid_q[w*8+k]) begin
					snap[w][63-8*k -: 8] = store_q[w][63-8*k -: 8];
				end else begin
					snap[w][63-8*k -: 8] = 8'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEQ_TAG;
			count_q <= '0;
			decl_q <= '0;
			second_q <= 1'b0;
			left_q <= '0;
			fail_q <= 1'b0;
			valid_q <= '0;
		end else if (accept) begin
			if (byte_item.last_byte) begin
				phase_q <= PH_SEQ_TAG;
				count_q <= '0;
				decl_q <= '0;
				second_q <= 1'b0;
				left_q <= '0;
				fail_q <= 1'b0;
				valid_q <= '0;
			end else begin
				phase_q <= phase_n;
				count_q <= count_n;
				decl_q <= decl_n;
				second_q <= second_n;
				left_q <= left_n;
				fail_q <= fail_n;
				if (put) begin
					valid_q[wr_pos] <= 1'b1;
				end else if (clr_half) begin
					if (second_q) valid_q[der2raw_pkg::STORE_BYTES-1:der2raw_pkg::COORD_BYTES] <= '0;
					else valid_q[der2raw_pkg::COORD_BYTES-1:0] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && put) begin
			store_q[wr_word][63-8*wr_lane -: 8] <= b;
		end
		if (load) begin
			buf_q <= snap;
			buf_ok_q <= ok_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (out_fire) begin
			busy_q <= !drain_done;
			idx_q <= idx_q + WA'(1);
		end
	end

	assign word_valid = busy_q;
	assign word_item.word_index = 3'(idx_q);
	assign word_item.out_word = buf_q[idx_q];
	assign word_item.ok = buf_ok_q;
	assign word_item.last_word = (idx_q == WA'(NW - 1));

	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> idx_q == '0)
		else $error("word run does not start at word zero");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && !word_item.ok) |-> word_item.out_word == 64'd0)
		else $error("failed signature delivers nonzero data");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 7'(der2raw_pkg::DER_MAX_BYTES + 1))
		else $error("byte count passed its saturation point");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy_q && idx_q == '0))
		else $error("final byte did not start a word run");

	a_put_range: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && put) |-> (left_q != 6'd0 && left_q <= 6'(der2raw_pkg::COORD_BYTES)))
		else $error("value byte written outside its coordinate");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_COUNT = 380;

	typedef enum logic [2:0] {
		WAIT_SEQ_TAG,
		WAIT_SEQ_LEN,
		WAIT_INT_TAG,
		WAIT_INT_LEN,
		WAIT_INT_LEAD,
		WAIT_AFTER_ZERO,
		IN_INT_BODY,
		PARSE_DONE
	} der_phase_e;

	class signature_scoreboard;
		der2raw_pkg::word_item_t expected_words[$];
		int errors;
		int words_checked;
		int ok_words;
		der_phase_e phase;
		int byte_count;
		int declared_len;
		bit second;
		int content_left;
		bit failed;
		logic [7:0] coord[der2raw_pkg::STORE_BYTES];

		function new();
			errors = 0;
			words_checked = 0;
			ok_words = 0;
			clear();
		endfunction

		function void clear();
			phase = WAIT_SEQ_TAG;
			byte_count = 0;
			declared_len = 0;
			second = 1'b0;
			content_left = 0;
			failed = 1'b0;
			foreach (coord[i]) coord[i] = 8'h00;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void store_value(logic [7:0] b);
			coord[int'(second) * der2raw_pkg::COORD_BYTES + der2raw_pkg::COORD_BYTES
				- content_left] = b;
			content_left--;
			if (content_left == 0) begin
				if (!second) begin
					second = 1'b1;
					phase = WAIT_INT_TAG;
				end else begin
					phase = PARSE_DONE;
				end
			end else begin
				phase = IN_INT_BODY;
			end
		endfunction

		function void parse_der_byte(logic [7:0] b);
			case (phase)
				WAIT_SEQ_TAG: begin
					if (b != der2raw_pkg::TAG_SEQUENCE) failed = 1'b1;
					else phase = WAIT_SEQ_LEN;
				end
				WAIT_SEQ_LEN: begin
					declared_len = b;
					phase = WAIT_INT_TAG;
				end
				WAIT_INT_TAG: begin
					if (b != der2raw_pkg::TAG_INTEGER) failed = 1'b1;
					else phase = WAIT_INT_LEN;
				end
				WAIT_INT_LEN: begin
					if (b == 8'h00 || int'(b) > der2raw_pkg::COORD_BYTES + 1) begin
						failed = 1'b1;
					end else begin
						content_left = b;
						for (int k = 0; k < der2raw_pkg::COORD_BYTES; k++)
							coord[int'(second) * der2raw_pkg::COORD_BYTES + k] = 8'h00;
						phase = WAIT_INT_LEAD;
					end
				end
				WAIT_INT_LEAD: begin
					// One zero byte may be dropped, but only ahead of a byte with its top bit set.
					if (b[7]) begin
						failed = 1'b1;
					end else if (b == 8'h00 && content_left > 1) begin
						content_left--;
						phase = WAIT_AFTER_ZERO;
					end else if (content_left > der2raw_pkg::COORD_BYTES) begin
						failed = 1'b1;
					end else begin
						store_value(b);
					end
				end
				WAIT_AFTER_ZERO: begin
					if (!b[7] || content_left > der2raw_pkg::COORD_BYTES) failed = 1'b1;
					else store_value(b);
				end
				IN_INT_BODY: store_value(b);
				default: failed = 1'b1;
			endcase
		endfunction

		function void note_byte(der2raw_pkg::byte_item_t it);
			der2raw_pkg::word_item_t w;
			bit good;
			if (byte_count <= der2raw_pkg::DER_MAX_BYTES) byte_count++;
			if (byte_count > der2raw_pkg::DER_MAX_BYTES) failed = 1'b1;
			if (!failed) parse_der_byte(it.data_byte);
			if (!it.last_byte) return;
			good = !failed && phase == PARSE_DONE && byte_count >= der2raw_pkg::DER_MIN_BYTES &&
				byte_count <= der2raw_pkg::DER_MAX_BYTES && declared_len + 2 == byte_count;
			for (int i = 0; i < der2raw_pkg::WORD_COUNT; i++) begin
				w.word_index = 3'(i);
				w.out_word = '0;
				if (good) begin
					for (int k = 0; k < 8; k++)
						w.out_word = {w.out_word[55:0], coord[i * 8 + k]};
				end
				w.ok = good;
				w.last_word = (i == der2raw_pkg::WORD_COUNT - 1);
				expected_words.push_back(w);
			end
			clear();
		endfunction

		function void report_field(string name, logic [63:0] want, logic [63:0] got);
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		endfunction

		function void check_word(der2raw_pkg::word_item_t got);
			der2raw_pkg::word_item_t want;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual index %0d word %h ok %b",
					$time, got.word_index, got.out_word, got.ok);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			words_checked++;
			if (want.ok) ok_words++;
			if (got.word_index !== want.word_index)
				report_field("word_index", want.word_index, got.word_index);
			if (got.out_word !== want.out_word)
				report_field("out_word", want.out_word, got.out_word);
			if (got.ok !== want.ok)
				report_field("ok", want.ok, got.ok);
			if (got.last_word !== want.last_word)
				report_field("last_word", want.last_word, got.last_word);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic byte_valid;
	logic byte_stall;
	der2raw_pkg::byte_item_t byte_item;
	logic word_valid;
	logic word_stall;
	der2raw_pkg::word_item_t word_item;
	logic rx_stall = 1'b0;
	logic hold_off = 1'b0;

	signature_scoreboard sb;
	logic [7:0] sig_bytes[$];
	logic [7:0] sig_body[$];
	bit tx_quiet;
	bit start_hold = 1'b0;
	int bytes_sent = 0;
	int signatures = 0;
	int cycles = 0;

	assign word_stall = rx_stall | hold_off;

	der_ecdsa_signature_to_raw_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.word_valid(word_valid),
		.word_stall(word_stall),
		.word_item(word_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// Mode 1 forces the top bit of the leading value byte, mode 2 clears it, 0 leaves it random.
	function automatic void append_integer(int vlen, int mode);
		logic [7:0] first;
		first = 8'($urandom_range(vlen > 1 ? 1 : 0, 255));
		if (mode == 1) first[7] = 1'b1;
		if (mode == 2) begin
			first[7] = 1'b0;
			if (vlen > 1 && first == 8'h00) first = 8'h01;
		end
		sig_body.push_back(der2raw_pkg::TAG_INTEGER);
		sig_body.push_back(8'(vlen + int'(first[7])));
		if (first[7]) sig_body.push_back(8'h00);
		sig_body.push_back(first);
		for (int i = 1; i < vlen; i++) sig_body.push_back(8'($urandom));
	endfunction

	function automatic void build_signature(int rlen, int slen, int rmode, int smode);
		sig_body.delete();
		append_integer(rlen, rmode);
		append_integer(slen, smode);
		sig_bytes.delete();
		sig_bytes.push_back(der2raw_pkg::TAG_SEQUENCE);
		sig_bytes.push_back(8'(sig_body.size()));
		foreach (sig_body[i]) sig_bytes.push_back(sig_body[i]);
	endfunction

	function automatic void make_noise(int n);
		sig_bytes.delete();
		for (int i = 0; i < n; i++) sig_bytes.push_back(8'($urandom));
	endfunction

	function automatic int pick_length();
		if ($urandom_range(0, 7) == 0) return $urandom_range(29, der2raw_pkg::COORD_BYTES);
		return $urandom_range(1, 8);
	endfunction

	// Mostly well-formed signatures; the rest get one kind of damage.
	function automatic void make_random_signature();
		int idx;
		int n;
		build_signature(pick_length(), pick_length(), 0, 0);
		idx = $urandom_range(0, sig_bytes.size() - 1);
		case ($urandom_range(0, 15))
			0: sig_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
			1: sig_bytes[idx] = 8'($urandom);
			2: begin
				n = $urandom_range(1, sig_bytes.size() - 1);
				while (sig_bytes.size() > n) sig_bytes.delete(sig_bytes.size() - 1);
			end
			3: begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) sig_bytes.push_back(8'($urandom));
			end
			4: sig_bytes[1] = 8'($urandom);
			5: make_noise($urandom_range(1, 90));
			6: begin
				sig_bytes[1] = sig_bytes[1] + 8'd1;
				sig_bytes[3] = sig_bytes[3] + 8'd1;
				sig_bytes.insert(4, 8'h00);
			end
			default: ;
		endcase
	endfunction

	task automatic send_byte(input der2raw_pkg::byte_item_t it);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		do @(posedge clk); while (byte_stall);
		sb.note_byte(it);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_signature();
		der2raw_pkg::byte_item_t it;
		tx_quiet = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < sig_bytes.size(); i++) begin
			it.data_byte = sig_bytes[i];
			it.last_byte = (i == sig_bytes.size() - 1);
			send_byte(it);
		end
		signatures++;
	endtask

	// Word receiver with random stalls and occasional stretches without any.
	initial begin
		int wait_cycles;
		int seen;
		bit rx_quiet;
		seen = 0;
		rx_quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (seen % 8 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
			wait_cycles = rx_quiet ? 0 : $urandom_range(0, 15);
			if (wait_cycles > 0) begin
				rx_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			rx_stall <= 1'b0;
			do @(posedge clk); while (!(word_valid && !word_stall));
			sb.check_word(word_item);
			seen++;
			@(negedge clk);
		end
	end

	// A long hold on the word side, so the buffer fills and the next final byte is held off.
	initial begin
		wait (start_hold);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		int directed_bytes;
		sb = new();
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_item = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Smallest legal signature, both values zero.
		sig_bytes = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h00, 8'h02, 8'h01, 8'h00};
		send_signature();
		start_hold = 1'b1;
		// Largest legal signature: both values need the extra zero byte.
		build_signature(der2raw_pkg::COORD_BYTES, der2raw_pkg::COORD_BYTES, 1, 1);
		send_signature();
		// Short r, so it is padded on the left.
		build_signature(1, 5, 2, 1);
		send_signature();
		// One byte beyond the maximum.
		build_signature(der2raw_pkg::COORD_BYTES, der2raw_pkg::COORD_BYTES, 1, 1);
		sig_bytes.push_back(8'h00);
		send_signature();
		// Far too long, so the byte count saturates.
		make_noise(74);
		send_signature();
		// Value of 33 bytes whose first byte is not zero.
		sig_bytes = '{8'h30, 8'h06, 8'h02, 8'h21, 8'h01, 8'h02, 8'h01, 8'h01};
		send_signature();
		// Wrong sequence tag.
		sig_bytes = '{8'h31, 8'h06, 8'h02, 8'h01, 8'h7f, 8'h02, 8'h01, 8'h01};
		send_signature();
		// Wrong integer tag.
		sig_bytes = '{8'h30, 8'h06, 8'h03, 8'h01, 8'h7f, 8'h02, 8'h01, 8'h01};
		send_signature();
		// Negative integer.
		sig_bytes = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h80, 8'h02, 8'h01, 8'h01};
		send_signature();
		// Zero byte that is not needed ahead of the value.
		sig_bytes = '{8'h30, 8'h07, 8'h02, 8'h02, 8'h00, 8'h7f, 8'h02, 8'h01, 8'h01};
		send_signature();
		// Empty integer.
		sig_bytes = '{8'h30, 8'h06, 8'h02, 8'h00, 8'h02, 8'h02, 8'h01, 8'h01};
		send_signature();
		// Integer length of 34.
		sig_bytes = '{8'h30, 8'h06, 8'h02, 8'h22, 8'h00, 8'hff, 8'h01, 8'h01};
		send_signature();
		// Ends before the second integer.
		sig_bytes = '{8'h30, 8'h06, 8'h02, 8'h01, 8'hff};
		send_signature();
		// Trailing byte after the second integer.
		sig_bytes = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h55, 8'h02, 8'h01, 8'haa, 8'h00};
		send_signature();
		// Sequence length does not match the total.
		sig_bytes = '{8'h30, 8'h07, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
		send_signature();
		// A lone final byte.
		sig_bytes = '{8'h30};
		send_signature();

		directed_bytes = bytes_sent;
		while (bytes_sent < ITEM_COUNT) begin
			make_random_signature();
			send_signature();
		end
		byte_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("Run covered %0d signatures in %0d bytes (%0d directed).",
			signatures, bytes_sent, directed_bytes);
		$display("Checked %0d result words, %0d of them from valid signatures.",
			sb.words_checked, sb.ok_words);
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
